@@ hw/rtl/lpr_pkg.sv @@
// Shared types and constants for the length-prefixed packet ring.
package lpr_pkg;

   // Widths that the item fields and registers fix.
   localparam int CNT_W      = 11;
   localparam int RSV_W      = 10;
   localparam int CSR_DATA_W = 32;
   localparam int CSR_ADDR_W = 3;

   // Register reset values and limits.
   localparam int RESET_RING_SIZE = 1024;
   localparam int RESET_RESERVE   = 10;
   localparam int MIN_RING_SIZE   = 5;

   // Register indexes, taken from the word address.
   localparam logic CSR_RING_SIZE = 1'b0;
   localparam logic CSR_RESERVE   = 1'b1;

   // Command codes of an input beat.
   localparam logic [1:0] CMD_BEGIN = 2'd0;
   localparam logic [1:0] CMD_WRITE = 2'd1;
   localparam logic [1:0] CMD_READ  = 2'd2;

   // Status codes of a result beat.
   localparam logic [2:0] ST_OK       = 3'd0;
   localparam logic [2:0] ST_FULL     = 3'd1;
   localparam logic [2:0] ST_EMPTY    = 3'd2;
   localparam logic [2:0] ST_CORRUPT  = 3'd3;
   localparam logic [2:0] ST_NO_WRITE = 3'd4;
   localparam logic [2:0] ST_BAD_LEN  = 3'd5;

   typedef struct packed {
      logic [1:0]       command;
      logic [7:0]       data_byte;
      logic [CNT_W-1:0] packet_length;
   } req_type;

   typedef struct packed {
      logic [2:0]       status;
      logic [7:0]       read_byte;
      logic             last_of_packet;
      logic [CNT_W-1:0] free_bytes;
      logic [CNT_W-1:0] used_bytes;
   } rsp_type;

   // Datapath operations that the controller issues.
   typedef enum logic [3:0] {
      OP_NONE,
      OP_LOAD_ITEM,
      OP_WBYTE,
      OP_HDR_WR_INIT,
      OP_HDR_WR,
      OP_HDR_RD_INIT,
      OP_HDR_RD,
      OP_TAKE,
      OP_HDR_TAKE,
      OP_CAP_BYTE,
      OP_FLUSH
   } dp_op_type;

   typedef struct packed {
      dp_op_type  op;
      logic       set_status;
      logic [2:0] status;
      logic       load_out;
   } dp_cmd_type;

   typedef struct packed {
      logic [1:0] command;
      logic       bad_len;
      logic       no_room;
      logic       wleft_zero;
      logic       rleft_zero;
      logic       ring_empty;
      logic       used_lt_hdr;
      logic       hdr_last;
      logic       hdr_bad;
      logic       out_free;
   } dp_stat_type;

endpackage

@@ hw/rtl/lpr_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
module lpr_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   // Write port and registered read port.
   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      rdata_ff <= mem_ff[raddr];
   end

   assign rdata = rdata_ff;

endmodule

@@ hw/rtl/lpr_ctrl.sv @@
// Controller state machine that sequences each command through the datapath.
module lpr_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   input  lpr_pkg::dp_stat_type dp_stat,
   output lpr_pkg::dp_cmd_type  dp_cmd
);

   typedef enum logic [3:0] {
      S_IDLE,
      S_DECODE,
      S_HDR_WR,
      S_HDR_RD,
      S_HDR_WAIT,
      S_HDR_CHK,
      S_READ_WAIT,
      S_LOAD
   } state_type;

   state_type state_ff;
   state_type state_in;

   // Next state and the datapath command of the current cycle.
   always_comb begin
      state_in          = state_ff;
      dp_cmd.op         = lpr_pkg::OP_NONE;
      dp_cmd.set_status = 1'b0;
      dp_cmd.status     = lpr_pkg::ST_OK;
      dp_cmd.load_out   = 1'b0;
      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               dp_cmd.op = lpr_pkg::OP_LOAD_ITEM;
               state_in  = S_DECODE;
            end
         end
         S_DECODE: begin
            state_in = S_LOAD;
            case (dp_stat.command)
               lpr_pkg::CMD_BEGIN: begin
                  if (dp_stat.bad_len) begin
                     dp_cmd.set_status = 1'b1;
                     dp_cmd.status     = lpr_pkg::ST_BAD_LEN;
                  end else if (dp_stat.no_room) begin
                     dp_cmd.set_status = 1'b1;
                     dp_cmd.status     = lpr_pkg::ST_FULL;
                  end else begin
                     dp_cmd.op = lpr_pkg::OP_HDR_WR_INIT;
                     state_in  = S_HDR_WR;
                  end
               end
               lpr_pkg::CMD_WRITE: begin
                  if (dp_stat.wleft_zero) begin
                     dp_cmd.set_status = 1'b1;
                     dp_cmd.status     = lpr_pkg::ST_NO_WRITE;
                  end else begin
                     dp_cmd.op = lpr_pkg::OP_WBYTE;
                  end
               end
               lpr_pkg::CMD_READ: begin
                  if (!dp_stat.rleft_zero) begin
                     dp_cmd.op = lpr_pkg::OP_TAKE;
                     state_in  = S_READ_WAIT;
                  end else if (dp_stat.ring_empty) begin
                     dp_cmd.set_status = 1'b1;
                     dp_cmd.status     = lpr_pkg::ST_EMPTY;
                  end else if (dp_stat.used_lt_hdr) begin
                     dp_cmd.op         = lpr_pkg::OP_FLUSH;
                     dp_cmd.set_status = 1'b1;
                     dp_cmd.status     = lpr_pkg::ST_CORRUPT;
                  end else begin
                     dp_cmd.op = lpr_pkg::OP_HDR_RD_INIT;
                     state_in  = S_HDR_RD;
                  end
               end
               default: begin
                  state_in = S_LOAD;
               end
            endcase
         end
         S_HDR_WR: begin
            dp_cmd.op = lpr_pkg::OP_HDR_WR;
            if (dp_stat.hdr_last) begin
               state_in = S_LOAD;
            end
         end
         S_HDR_RD: begin
            dp_cmd.op = lpr_pkg::OP_HDR_RD;
            if (dp_stat.hdr_last) begin
               state_in = S_HDR_WAIT;
            end
         end
         S_HDR_WAIT: begin
            state_in = S_HDR_CHK;
         end
         S_HDR_CHK: begin
            if (dp_stat.hdr_bad) begin
               dp_cmd.op         = lpr_pkg::OP_FLUSH;
               dp_cmd.set_status = 1'b1;
               dp_cmd.status     = lpr_pkg::ST_CORRUPT;
               state_in          = S_LOAD;
            end else begin
               dp_cmd.op = lpr_pkg::OP_HDR_TAKE;
               state_in  = S_READ_WAIT;
            end
         end
         S_READ_WAIT: begin
            dp_cmd.op = lpr_pkg::OP_CAP_BYTE;
            state_in  = S_LOAD;
         end
         S_LOAD: begin
            if (dp_stat.out_free) begin
               dp_cmd.load_out = 1'b1;
               state_in        = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // State register.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   assign req_stall = (state_ff != S_IDLE);

endmodule

@@ hw/rtl/lpr_datapath.sv @@
// Datapath: pointers, cursors, header handling, registers and the result register.
module lpr_datapath #(
   parameter int RING_DEPTH   = 1024,
   parameter int HEADER_BYTES = 4
) (
   input  logic                             clock,
   input  logic                             reset,
   input  lpr_pkg::req_type                 req_data,
   output lpr_pkg::rsp_type                 rsp_data,
   output logic                             rsp_valid,
   input  logic                             rsp_stall,
   input  logic                             psel,
   input  logic                             penable,
   input  logic                             pwrite,
   input  logic [lpr_pkg::CSR_ADDR_W-1:0]   paddr,
   input  logic [lpr_pkg::CSR_DATA_W-1:0]   pwdata,
   output logic [lpr_pkg::CSR_DATA_W-1:0]   prdata,
   input  lpr_pkg::dp_cmd_type              dp_cmd,
   output lpr_pkg::dp_stat_type             dp_stat
);

   localparam int CNT_W    = lpr_pkg::CNT_W;
   localparam int RSV_W    = lpr_pkg::RSV_W;
   localparam int PTR_W    = $clog2(RING_DEPTH);
   localparam int CMP_W    = (PTR_W + 1 > CNT_W) ? PTR_W + 1 : CNT_W;
   localparam int HCNT_W   = (HEADER_BYTES > 1) ? $clog2(HEADER_BYTES) : 1;
   localparam int HDR_BITS = 8 * HEADER_BYTES;
   localparam logic [CNT_W-1:0] SIZE_RESET = CNT_W'((RING_DEPTH < lpr_pkg::RESET_RING_SIZE)
                                                   ? RING_DEPTH : lpr_pkg::RESET_RING_SIZE);

   // Ring registers and state.
   logic [CNT_W-1:0]  size_ff;
   logic [RSV_W-1:0]  reserve_ff;
   logic [PTR_W-1:0]  cwp_ff;
   logic [PTR_W-1:0]  crp_ff;
   logic [PTR_W-1:0]  wcur_ff;
   logic [CNT_W-1:0]  wleft_ff;
   logic [PTR_W-1:0]  rcur_ff;
   logic [CNT_W-1:0]  rleft_ff;

   // Item and header scan registers.
   lpr_pkg::req_type  item_ff;
   logic [PTR_W-1:0]  scan_ff;
   logic [HCNT_W-1:0] hcnt_ff;
   logic [31:0]       plen_ff;
   logic              cap_pend_ff;
   logic [2:0]        status_ff;
   logic [7:0]        rbyte_ff;
   logic              last_ff;

   // Result register.
   lpr_pkg::rsp_type  rsp_ff;
   logic              rsp_valid_ff;

   // Memory port signals.
   logic              mem_we;
   logic [PTR_W-1:0]  mem_waddr;
   logic [7:0]        mem_wdata;
   logic [PTR_W-1:0]  mem_raddr;
   logic [7:0]        mem_rdata;

   logic [CMP_W-1:0]  used_wide;
   logic [CNT_W-1:0]  used;
   logic [CNT_W:0]    taken;
   logic [CNT_W-1:0]  free;
   logic [CNT_W:0]    need;
   logic [CNT_W+1:0]  need_used;
   logic [31:0]       plen_val;
   logic [31:0]       len_shift;
   logic [31:0]       hdr_shift;
   logic [PTR_W-1:0]  wcur_next;
   logic [PTR_W-1:0]  rcur_next;
   logic [PTR_W-1:0]  scan_next;
   logic              csr_wr;
   logic [CNT_W-1:0]  size_wr;

   // Step a ring position forward, wrapping at the ring size.
   function automatic logic [PTR_W-1:0] next_ptr(input logic [PTR_W-1:0] p,
                                                 input logic [CNT_W-1:0] size);
      logic [CMP_W-1:0] n;
      n = CMP_W'(p) + CMP_W'(1);
      next_ptr = (n >= CMP_W'(size)) ? '0 : n[PTR_W-1:0];
   endfunction

   assign wcur_next = next_ptr(wcur_ff, size_ff);
   assign rcur_next = next_ptr(rcur_ff, size_ff);
   assign scan_next = next_ptr(scan_ff, size_ff);

   // Committed bytes and free space after the reserve.
   always_comb begin
      if (cwp_ff >= crp_ff) begin
         used_wide = CMP_W'(cwp_ff) - CMP_W'(crp_ff);
      end else begin
         used_wide = CMP_W'(size_ff) - CMP_W'(crp_ff) + CMP_W'(cwp_ff);
      end
      used  = used_wide[CNT_W-1:0];
      taken = {1'b0, used} + (CNT_W+1)'(reserve_ff);
      free  = (taken >= {1'b0, size_ff}) ? '0 : size_ff - taken[CNT_W-1:0];
   end

   // Begin-write checks on the stored length.
   assign need      = (CNT_W+1)'(item_ff.packet_length) + (CNT_W+1)'(HEADER_BYTES);
   assign need_used = (CNT_W+2)'(need) + (CNT_W+2)'(used);
   assign len_shift = 32'(item_ff.packet_length) >> HDR_BITS;

   // Header value gathered from the top of the shift register.
   assign plen_val  = plen_ff >> (32 - HDR_BITS);
   assign hdr_shift = 32'(item_ff.packet_length) >> {hcnt_ff, 3'b000};

   // Status toward the controller.
   always_comb begin
      dp_stat.command     = item_ff.command;
      dp_stat.bad_len     = (item_ff.packet_length == '0) || (len_shift != 32'd0);
      dp_stat.no_room     = (need > {1'b0, free}) || (need_used >= (CNT_W+2)'(size_ff));
      dp_stat.wleft_zero  = (wleft_ff == '0);
      dp_stat.rleft_zero  = (rleft_ff == '0);
      dp_stat.ring_empty  = (crp_ff == cwp_ff);
      dp_stat.used_lt_hdr = (used < CNT_W'(HEADER_BYTES));
      dp_stat.hdr_last    = (hcnt_ff == HCNT_W'(HEADER_BYTES - 1));
      dp_stat.hdr_bad     = (plen_val == 32'd0)
                          || (plen_val > 32'(used - CNT_W'(HEADER_BYTES)));
      dp_stat.out_free    = !rsp_valid_ff || !rsp_stall;
   end

   // Memory write and read addressing.
   always_comb begin
      mem_we    = 1'b0;
      mem_waddr = wcur_ff;
      mem_wdata = item_ff.data_byte;
      mem_raddr = rcur_ff;
      case (dp_cmd.op)
         lpr_pkg::OP_WBYTE: begin
            mem_we = 1'b1;
         end
         lpr_pkg::OP_HDR_WR: begin
            mem_we    = 1'b1;
            mem_waddr = scan_ff;
            mem_wdata = hdr_shift[7:0];
         end
         lpr_pkg::OP_HDR_RD, lpr_pkg::OP_HDR_TAKE: begin
            mem_raddr = scan_ff;
         end
         default: begin
            mem_raddr = rcur_ff;
         end
      endcase
   end

   lpr_ram #(
      .WIDTH (8),
      .DEPTH (RING_DEPTH)
   ) u_ram (
      .clock (clock),
      .we    (mem_we),
      .waddr (mem_waddr),
      .wdata (mem_wdata),
      .raddr (mem_raddr),
      .rdata (mem_rdata)
   );

   // Configuration write decode and ring size clamp.
   assign csr_wr = psel && penable && pwrite;
   always_comb begin
      size_wr = pwdata[CNT_W-1:0];
      if (size_wr < CNT_W'(lpr_pkg::MIN_RING_SIZE)) begin
         size_wr = CNT_W'(lpr_pkg::MIN_RING_SIZE);
      end else if (32'(size_wr) > 32'(RING_DEPTH)) begin
         size_wr = CNT_W'(RING_DEPTH);
      end
   end

   always_comb begin
      if (paddr[2] == lpr_pkg::CSR_RING_SIZE) begin
         prdata = lpr_pkg::CSR_DATA_W'(size_ff);
      end else begin
         prdata = lpr_pkg::CSR_DATA_W'(reserve_ff);
      end
   end

   // Control state: pointers, cursors, registers and result valid.
   always_ff @(posedge clock) begin
      if (reset) begin
         size_ff      <= SIZE_RESET;
         reserve_ff   <= RSV_W'(lpr_pkg::RESET_RESERVE);
         cwp_ff       <= '0;
         crp_ff       <= '0;
         wcur_ff      <= '0;
         wleft_ff     <= '0;
         rcur_ff      <= '0;
         rleft_ff     <= '0;
         cap_pend_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         // A header read returns its byte in the next cycle.
         cap_pend_ff <= (dp_cmd.op == lpr_pkg::OP_HDR_RD);
         case (dp_cmd.op)
            lpr_pkg::OP_WBYTE: begin
               wcur_ff  <= wcur_next;
               wleft_ff <= wleft_ff - CNT_W'(1);
               if (wleft_ff == CNT_W'(1)) begin
                  cwp_ff <= wcur_next;
               end
            end
            lpr_pkg::OP_HDR_WR: begin
               if (dp_stat.hdr_last) begin
                  wcur_ff  <= scan_next;
                  wleft_ff <= item_ff.packet_length;
               end
            end
            lpr_pkg::OP_TAKE: begin
               rcur_ff  <= rcur_next;
               rleft_ff <= rleft_ff - CNT_W'(1);
               if (rleft_ff == CNT_W'(1)) begin
                  crp_ff <= rcur_next;
               end
            end
            lpr_pkg::OP_HDR_TAKE: begin
               rcur_ff  <= scan_next;
               rleft_ff <= plen_val[CNT_W-1:0] - CNT_W'(1);
               if (plen_val == 32'd1) begin
                  crp_ff <= scan_next;
               end
            end
            lpr_pkg::OP_FLUSH: begin
               cwp_ff   <= '0;
               crp_ff   <= '0;
               wcur_ff  <= '0;
               wleft_ff <= '0;
               rcur_ff  <= '0;
               rleft_ff <= '0;
            end
            default: begin
            end
         endcase

         // A ring size write flushes the ring; writes must come only while idle, which the block does not enforce.
         if (csr_wr) begin
            if (paddr[2] == lpr_pkg::CSR_RING_SIZE) begin
               size_ff  <= size_wr;
               cwp_ff   <= '0;
               crp_ff   <= '0;
               wcur_ff  <= '0;
               wleft_ff <= '0;
               rcur_ff  <= '0;
               rleft_ff <= '0;
            end else begin
               reserve_ff <= pwdata[RSV_W-1:0];
            end
         end

         if (dp_cmd.load_out) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_valid_ff && !rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // Payload registers: item, header scan, partial result and result beat.
   always_ff @(posedge clock) begin
      if (dp_cmd.op == lpr_pkg::OP_LOAD_ITEM) begin
         item_ff   <= req_data;
         status_ff <= lpr_pkg::ST_OK;
         rbyte_ff  <= 8'd0;
         last_ff   <= 1'b0;
      end
      if (dp_cmd.set_status) begin
         status_ff <= dp_cmd.status;
      end
      case (dp_cmd.op)
         lpr_pkg::OP_HDR_WR_INIT: begin
            scan_ff <= cwp_ff;
            hcnt_ff <= '0;
         end
         lpr_pkg::OP_HDR_RD_INIT: begin
            scan_ff <= crp_ff;
            hcnt_ff <= '0;
            plen_ff <= 32'd0;
         end
         lpr_pkg::OP_HDR_WR, lpr_pkg::OP_HDR_RD: begin
            scan_ff <= scan_next;
            hcnt_ff <= hcnt_ff + HCNT_W'(1);
         end
         lpr_pkg::OP_TAKE: begin
            if (rleft_ff == CNT_W'(1)) begin
               last_ff <= 1'b1;
            end
         end
         lpr_pkg::OP_HDR_TAKE: begin
            if (plen_val == 32'd1) begin
               last_ff <= 1'b1;
            end
         end
         lpr_pkg::OP_CAP_BYTE: begin
            rbyte_ff <= mem_rdata;
         end
         default: begin
            hcnt_ff <= hcnt_ff;
         end
      endcase

      // Header bytes arrive in the cycle after their read, low byte first.
      if (cap_pend_ff) begin
         plen_ff <= {mem_rdata, plen_ff[31:8]};
      end

      if (dp_cmd.load_out) begin
         rsp_ff.status         <= status_ff;
         rsp_ff.read_byte      <= rbyte_ff;
         rsp_ff.last_of_packet <= last_ff;
         rsp_ff.free_bytes     <= free;
         rsp_ff.used_bytes     <= used;
      end
   end

   assign rsp_data  = rsp_ff;
   assign rsp_valid = rsp_valid_ff;

endmodule

@@ hw/rtl/length_prefixed_packet_ring_top.sv @@
// Top level of the length-prefixed packet ring.
//
// The block keeps variable-length packets in a byte ring, each behind a
// HEADER_BYTES little-endian length header, and takes one command beat at a
// time: begin a packet write, write one payload byte, or read the next payload
// byte. Every command beat yields exactly one result beat with a status, the
// read byte, an end-of-packet flag and the used and free byte counts after the
// command. A command runs from acceptance to its result through a sequence
// of controller states over the single-write, single-read ring memory. A
// payload write, a rejected begin, an unused command, an empty read or a
// read that finds fewer committed bytes than a header goes from decode
// straight to the output load, and a read inside a packet first takes its
// byte from the memory. An accepted begin writes one header byte per cycle.
// The first read of a packet fetches the header one byte per cycle and
// checks it, and ends there, flushing the ring, when that header proves
// broken. A result enters the output register only once that is free, so
// a result still stalled there delays the next one.
// A finished result waits in an output register, so the next command beat is
// taken while it is still stalled. The ring memory needs no clearing after
// reset. Registers: ring_size at byte address 0 (a write flushes the ring) and
// reserve_bytes at byte address 4; write them only while the block is idle.
module length_prefixed_packet_ring_top #(
   parameter int RING_DEPTH   = 1024,
   parameter int HEADER_BYTES = 4
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   output logic                           req_stall,
   input  lpr_pkg::req_type               req_data,
   output logic                           rsp_valid,
   input  logic                           rsp_stall,
   output lpr_pkg::rsp_type               rsp_data,
   input  logic                           psel,
   input  logic                           penable,
   input  logic                           pwrite,
   input  logic [lpr_pkg::CSR_ADDR_W-1:0] paddr,
   input  logic [lpr_pkg::CSR_DATA_W-1:0] pwdata,
   output logic [lpr_pkg::CSR_DATA_W-1:0] prdata,
   output logic                           pready
);

   lpr_pkg::dp_cmd_type  dp_cmd;
   lpr_pkg::dp_stat_type dp_stat;

   // Register accesses always complete in their access cycle.
   assign pready = 1'b1;

   lpr_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .dp_stat   (dp_stat),
      .dp_cmd    (dp_cmd)
   );

   lpr_datapath #(
      .RING_DEPTH   (RING_DEPTH),
      .HEADER_BYTES (HEADER_BYTES)
   ) u_datapath (
      .clock     (clock),
      .reset     (reset),
      .req_data  (req_data),
      .rsp_data  (rsp_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .psel      (psel),
      .penable   (penable),
      .pwrite    (pwrite),
      .paddr     (paddr),
      .pwdata    (pwdata),
      .prdata    (prdata),
      .dp_cmd    (dp_cmd),
      .dp_stat   (dp_stat)
   );

endmodule

@@ hw/rtl/lpr_checker.sv @@
// Port-level checker for the packet ring, bound to the top level.
module lpr_checker (
   input logic             clock,
   input logic             reset,
   input logic             req_valid,
   input logic             req_stall,
   input logic             rsp_valid,
   input logic             rsp_stall,
   input lpr_pkg::rsp_type rsp_data
);

   // A stalled result beat stays offered.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid)
      else $error("result beat dropped while stalled");

   // A stalled result beat keeps its payload.
   a_rsp_stable: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> $stable(rsp_data))
      else $error("result payload changed while stalled");

   // Commands run one at a time, so an accepted beat closes the input.
   a_one_at_a_time: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> req_stall)
      else $error("input accepted while a command is in progress");

   // No result beat appears straight out of reset.
   a_reset_quiet: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result beat present after reset");

endmodule

bind length_prefixed_packet_ring_top lpr_checker u_lpr_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_valid),
   .req_stall (req_stall),
   .rsp_valid (rsp_valid),
   .rsp_stall (rsp_stall),
   .rsp_data  (rsp_data)
);

@@ tb/sv/length_prefixed_packet_ring_top_test.sv @@
// Self-checking testbench for the length-prefixed packet ring: directed and random command beats.
module length_prefixed_packet_ring_top_test;

   localparam int RING_DEPTH    = 1024;
   localparam int HDR_LEN       = 4;
   localparam int CLK_PERIOD    = 12;
   localparam int MAX_WAIT      = 18;
   localparam int SETTLE_CYCLES = 16;
   localparam int LIMIT_CYCLES  = 800000;

   // The command code that the block ignores.
   localparam logic [1:0] CMD_UNUSED = 2'd3;

   logic                           clock     = 1'b0;
   logic                           reset     = 1'b1;
   logic                           req_valid = 1'b0;
   logic                           req_stall;
   lpr_pkg::req_type               req_data  = '0;
   logic                           rsp_valid;
   logic                           rsp_stall = 1'b0;
   lpr_pkg::rsp_type               rsp_data;
   logic                           psel      = 1'b0;
   logic                           penable   = 1'b0;
   logic                           pwrite    = 1'b0;
   logic [lpr_pkg::CSR_ADDR_W-1:0] paddr     = '0;
   logic [lpr_pkg::CSR_DATA_W-1:0] pwdata    = '0;
   logic [lpr_pkg::CSR_DATA_W-1:0] prdata;
   logic                           pready;

   // Predicted ring contents, pointers and register values.
   logic [7:0]  ring_image [RING_DEPTH];
   int unsigned ring_len;
   int unsigned keep_free;
   int unsigned wr_commit;
   int unsigned rd_commit;
   int unsigned wr_pos;
   int unsigned wr_remaining;
   int unsigned rd_pos;
   int unsigned rd_remaining;

   lpr_pkg::rsp_type expected_rsp_q [$];
   lpr_pkg::rsp_type oldest;
   int               mismatch_count = 0;
   bit               idle_on        = 1'b1;
   int               stall_hold     = 0;

   length_prefixed_packet_ring_top #(
      .RING_DEPTH   (RING_DEPTH),
      .HEADER_BYTES (HDR_LEN)
   ) u_top (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data),
      .psel      (psel),
      .penable   (penable),
      .pwrite    (pwrite),
      .paddr     (paddr),
      .pwdata    (pwdata),
      .prdata    (prdata),
      .pready    (pready)
   );

   initial begin
      forever #(CLK_PERIOD / 2) clock = ~clock;
   end

   // Ring position arithmetic on the predicted state.
   function automatic int unsigned next_slot(int unsigned p);
      return (p + 1 >= ring_len) ? 0 : p + 1;
   endfunction

   function automatic int unsigned bytes_used();
      if (wr_commit >= rd_commit)
         return wr_commit - rd_commit;
      return ring_len - rd_commit + wr_commit;
   endfunction

   function automatic int unsigned bytes_free();
      int unsigned taken;
      taken = bytes_used() + keep_free;
      return (taken >= ring_len) ? 0 : ring_len - taken;
   endfunction

   function automatic void flush_ring();
      wr_commit    = 0;
      rd_commit    = 0;
      wr_pos       = 0;
      wr_remaining = 0;
      rd_pos       = 0;
      rd_remaining = 0;
   endfunction

   // Pops one payload byte; the read pointer commits on the packet's last byte.
   function automatic logic [7:0] take_payload(output bit last);
      logic [7:0] b;
      b = ring_image[rd_pos];
      rd_pos = next_slot(rd_pos);
      rd_remaining--;
      last = (rd_remaining == 0);
      if (last)
         rd_commit = rd_pos;
      return b;
   endfunction

   // Works out the result beat of one command beat and updates the ring state.
   function automatic lpr_pkg::rsp_type ring_predict(lpr_pkg::req_type item);
      lpr_pkg::rsp_type r;
      int unsigned      need;
      int unsigned      used;
      int unsigned      p;
      int unsigned      plen;
      int               i;
      bit               last;
      r      = '0;
      last   = 1'b0;
      case (item.command)
         lpr_pkg::CMD_BEGIN: begin
            need = item.packet_length + HDR_LEN;
            used = bytes_used();
            // An 11-bit length always fits a 4-byte header, so only zero is bad.
            if (item.packet_length == 0) begin
               r.status = lpr_pkg::ST_BAD_LEN;
            end else if (need > bytes_free() || need + used >= ring_len) begin
               r.status = lpr_pkg::ST_FULL;
            end else begin
               p = wr_commit;
               for (i = 0; i < HDR_LEN; i++) begin
                  ring_image[p] = 8'(item.packet_length >> (8 * i));
                  p = next_slot(p);
               end
               wr_pos       = p;
               wr_remaining = item.packet_length;
            end
         end
         lpr_pkg::CMD_WRITE: begin
            if (wr_remaining == 0) begin
               r.status = lpr_pkg::ST_NO_WRITE;
            end else begin
               ring_image[wr_pos] = item.data_byte;
               wr_pos = next_slot(wr_pos);
               wr_remaining--;
               if (wr_remaining == 0)
                  wr_commit = wr_pos;
            end
         end
         lpr_pkg::CMD_READ: begin
            if (rd_remaining != 0) begin
               r.read_byte = take_payload(last);
            end else if (rd_commit == wr_commit) begin
               r.status = lpr_pkg::ST_EMPTY;
            end else begin
               used = bytes_used();
               if (used < HDR_LEN) begin
                  flush_ring();
                  r.status = lpr_pkg::ST_CORRUPT;
               end else begin
                  // Parse the little-endian length header at the packet start.
                  p    = rd_commit;
                  plen = 0;
                  for (i = 0; i < HDR_LEN; i++) begin
                     plen |= int'(ring_image[p]) << (8 * i);
                     p = next_slot(p);
                  end
                  if (plen == 0 || plen > used - HDR_LEN) begin
                     flush_ring();
                     r.status = lpr_pkg::ST_CORRUPT;
                  end else begin
                     rd_pos       = p;
                     rd_remaining = plen;
                     r.read_byte  = take_payload(last);
                  end
               end
            end
         end
         default: begin
         end
      endcase
      r.last_of_packet = last;
      r.free_bytes     = lpr_pkg::CNT_W'(bytes_free());
      r.used_bytes     = lpr_pkg::CNT_W'(bytes_used());
      return r;
   endfunction

   function automatic lpr_pkg::req_type make_item(logic [1:0] cmd, logic [7:0] data,
                                                  logic [lpr_pkg::CNT_W-1:0] len);
      lpr_pkg::req_type item;
      item.command       = cmd;
      item.data_byte     = data;
      item.packet_length = len;
      return item;
   endfunction

   task automatic report_mismatch(string what, int got, int want);
      $display("MISMATCH at %0t: %s got %0d, expected %0d", $time, what, got, want);
      mismatch_count++;
   endtask

   // Sends one command beat after a random gap and predicts its result.
   task automatic send_command(lpr_pkg::req_type item);
      int gap;
      gap = idle_on ? $urandom_range(0, MAX_WAIT) : 0;
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= item;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      expected_rsp_q.push_back(ring_predict(item));
   endtask

   // Waits until every predicted result has arrived and the block has settled.
   task automatic wait_idle();
      req_valid <= 1'b0;
      while (expected_rsp_q.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // Register write: a setup cycle, then an access cycle.
   task automatic csr_write(logic index, logic [lpr_pkg::CSR_DATA_W-1:0] value);
      int unsigned v;
      wait_idle();
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= lpr_pkg::CSR_ADDR_W'({index, 2'b00});
      pwdata  <= value;
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      psel    <= 1'b0;
      penable <= 1'b0;
      pwrite  <= 1'b0;
      if (index == lpr_pkg::CSR_RING_SIZE) begin
         v = value[lpr_pkg::CNT_W-1:0];
         if (v < lpr_pkg::MIN_RING_SIZE)
            v = lpr_pkg::MIN_RING_SIZE;
         if (v > RING_DEPTH)
            v = RING_DEPTH;
         ring_len = v;
         flush_ring();
      end else begin
         keep_free = value[lpr_pkg::RSV_W-1:0];
      end
   endtask

   // Error codes, length extremes, a dropped open write and single-byte packets.
   task automatic test_default_directed();
      send_command(make_item(lpr_pkg::CMD_READ, 8'h00, 11'd0));
      send_command(make_item(lpr_pkg::CMD_WRITE, 8'h00, 11'd0));
      send_command(make_item(CMD_UNUSED, 8'hFF, 11'h7FF));
      send_command(make_item(lpr_pkg::CMD_BEGIN, 8'h00, 11'd0));
      send_command(make_item(lpr_pkg::CMD_BEGIN, 8'hFF, 11'h7FF));
      send_command(make_item(lpr_pkg::CMD_BEGIN, 8'h00, 11'd1024));
      // Exactly the free space after the reserve; dropped by the next begin.
      send_command(make_item(lpr_pkg::CMD_BEGIN, 8'h00, 11'd1010));
      send_command(make_item(lpr_pkg::CMD_BEGIN, 8'h00, 11'd3));
      send_command(make_item(lpr_pkg::CMD_WRITE, 8'h00, 11'd0));
      send_command(make_item(lpr_pkg::CMD_WRITE, 8'hFF, 11'h7FF));
      send_command(make_item(lpr_pkg::CMD_BEGIN, 8'h00, 11'd2));
      send_command(make_item(lpr_pkg::CMD_WRITE, 8'hA5, 11'd0));
      send_command(make_item(lpr_pkg::CMD_WRITE, 8'h5A, 11'd0));
      send_command(make_item(lpr_pkg::CMD_READ, 8'h00, 11'd0));
      send_command(make_item(lpr_pkg::CMD_READ, 8'h00, 11'd0));
      send_command(make_item(lpr_pkg::CMD_READ, 8'h00, 11'd0));
      send_command(make_item(lpr_pkg::CMD_BEGIN, 8'h00, 11'd1));
      send_command(make_item(lpr_pkg::CMD_WRITE, 8'hFF, 11'd0));
      send_command(make_item(lpr_pkg::CMD_READ, 8'h00, 11'd0));
   endtask

   // A six-byte ring: the full test, the one open byte and a wrapped header.
   task automatic test_tiny_ring();
      csr_write(lpr_pkg::CSR_RING_SIZE, 32'd6);
      csr_write(lpr_pkg::CSR_RESERVE, 32'd0);
      send_command(make_item(lpr_pkg::CMD_BEGIN, 8'h00, 11'd1));
      send_command(make_item(lpr_pkg::CMD_WRITE, 8'h11, 11'd0));
      send_command(make_item(lpr_pkg::CMD_BEGIN, 8'h00, 11'd1));
      send_command(make_item(lpr_pkg::CMD_READ, 8'h00, 11'd0));
      send_command(make_item(lpr_pkg::CMD_BEGIN, 8'h00, 11'd1));
      send_command(make_item(lpr_pkg::CMD_WRITE, 8'h22, 11'd0));
      send_command(make_item(lpr_pkg::CMD_READ, 8'h00, 11'd0));
      send_command(make_item(lpr_pkg::CMD_READ, 8'h00, 11'd0));
   endtask

   // Mostly small packets, a few up to the ring size or 300, whichever is smaller.
   function automatic int unsigned pick_length();
      int unsigned cap;
      int          roll;
      cap  = (ring_len > 300) ? 300 : ring_len;
      roll = $urandom_range(0, 9);
      if (roll < 7)
         return $urandom_range(1, 12);
      if (roll < 9)
         return $urandom_range(1, (cap > 64) ? 64 : cap);
      return $urandom_range(1, cap);
   endfunction

   // Random traffic: well-formed packet writes and reads, with some noise.
   task automatic run_traffic(int items, int read_pct);
      lpr_pkg::req_type item;
      int               roll;
      int               n;
      for (n = 0; n < items; n++) begin
         if ($urandom_range(0, 39) == 0)
            idle_on = ($urandom_range(0, 3) != 0);
         item.command       = lpr_pkg::CMD_READ;
         item.data_byte     = 8'($urandom);
         item.packet_length = lpr_pkg::CNT_W'($urandom);
         roll = $urandom_range(0, 99);
         if (roll >= 90) begin
            case ($urandom_range(0, 3))
               0: item.command = CMD_UNUSED;
               1: begin
                  item.command       = lpr_pkg::CMD_BEGIN;
                  item.packet_length = '0;
               end
               2: begin
                  item.command       = lpr_pkg::CMD_BEGIN;
                  item.packet_length = lpr_pkg::CNT_W'($urandom_range(1024, 2047));
               end
               default: item.command = lpr_pkg::CMD_WRITE;
            endcase
         end else if (wr_remaining > 0) begin
            if (roll < read_pct / 2) begin
               item.command = lpr_pkg::CMD_READ;
            end else if (roll < 85) begin
               item.command = lpr_pkg::CMD_WRITE;
            end else begin
               item.command       = lpr_pkg::CMD_BEGIN;
               item.packet_length = lpr_pkg::CNT_W'(pick_length());
            end
         end else if (roll >= read_pct) begin
            item.command       = lpr_pkg::CMD_BEGIN;
            item.packet_length = lpr_pkg::CNT_W'(pick_length());
         end
         send_command(item);
      end
   endtask

   // Several register settings, the extremes among them.
   task automatic test_random_traffic();
      int k;
      csr_write(lpr_pkg::CSR_RING_SIZE, lpr_pkg::RESET_RING_SIZE);
      csr_write(lpr_pkg::CSR_RESERVE, lpr_pkg::RESET_RESERVE);
      run_traffic(250, 40);
      csr_write(lpr_pkg::CSR_RING_SIZE, 32'd6);
      csr_write(lpr_pkg::CSR_RESERVE, 32'd0);
      run_traffic(200, 45);
      csr_write(lpr_pkg::CSR_RING_SIZE, 32'd37);
      csr_write(lpr_pkg::CSR_RESERVE, 32'd3);
      run_traffic(250, 20);
      // All ones: the size clamps to the depth and the reserve leaves at most one byte free.
      csr_write(lpr_pkg::CSR_RING_SIZE, 32'hFFFF_FFFF);
      csr_write(lpr_pkg::CSR_RESERVE, 32'hFFFF_FFFF);
      run_traffic(100, 40);
      // Below the minimum size: the size clamps up to five.
      csr_write(lpr_pkg::CSR_RING_SIZE, 32'd2);
      csr_write(lpr_pkg::CSR_RESERVE, 32'd0);
      run_traffic(100, 40);
      for (k = 0; k < 3; k++) begin
         csr_write(lpr_pkg::CSR_RING_SIZE,
                   ($urandom & 32'hFFFF_F800) | $urandom_range(5, 300));
         run_traffic(100, $urandom_range(15, 50));
         // A new reserve while packets stay in the ring.
         csr_write(lpr_pkg::CSR_RESERVE,
                   ($urandom & 32'hFFFF_FC00) | $urandom_range(0, 20));
         run_traffic(100, $urandom_range(15, 50));
      end
   endtask

   // Result checker and receiver stall; a new stall is drawn per accepted beat.
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_rsp_q.size() == 0) begin
            report_mismatch("result beat with nothing expected, status", rsp_data.status, 0);
         end else begin
            oldest = expected_rsp_q.pop_front();
            if (rsp_data.status != oldest.status)
               report_mismatch("status", rsp_data.status, oldest.status);
            if (rsp_data.read_byte != oldest.read_byte)
               report_mismatch("read_byte", rsp_data.read_byte, oldest.read_byte);
            if (rsp_data.last_of_packet != oldest.last_of_packet)
               report_mismatch("last_of_packet", rsp_data.last_of_packet,
                               oldest.last_of_packet);
            if (rsp_data.free_bytes != oldest.free_bytes)
               report_mismatch("free_bytes", rsp_data.free_bytes, oldest.free_bytes);
            if (rsp_data.used_bytes != oldest.used_bytes)
               report_mismatch("used_bytes", rsp_data.used_bytes, oldest.used_bytes);
         end
         stall_hold = idle_on ? $urandom_range(0, MAX_WAIT) : 0;
      end else if (stall_hold > 0) begin
         stall_hold--;
      end
      rsp_stall <= (stall_hold > 0);
   end

   // Run limit.
   initial begin
      #(LIMIT_CYCLES * CLK_PERIOD);
      $display("Mismatches found");
      $finish;
   end

   // Test sequence.
   initial begin
      int i;
      for (i = 0; i < RING_DEPTH; i++)
         ring_image[i] = '0;
      ring_len  = lpr_pkg::RESET_RING_SIZE;
      keep_free = lpr_pkg::RESET_RESERVE;
      flush_ring();
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      test_default_directed();
      test_tiny_ring();
      test_random_traffic();
      wait_idle();
      if (mismatch_count == 0)
         $display("No mismatches found");
      else
         $display("Mismatches found");
      $finish;
   end

endmodule
